/* hdl/hunting_table_linear_interp_assert.svh */
// assertion macros for the table interpolator checker
// no dependencies
`ifndef HUNTING_TABLE_LINEAR_INTERP_ASSERT_SVH
`define HUNTING_TABLE_LINEAR_INTERP_ASSERT_SVH
`define HTLI_ASSERT_IMP(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("check failed");
`define HTLI_ASSERT_NXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("check failed");
`endif

/* hdl/htli_pkg.sv */
// shared constants and types for the table interpolator
// no dependencies
package htli_pkg;
   localparam int MaxPoints = 256;
   localparam int MaxCurves = 4;
   localparam int FracBits  = 16;
   localparam int IdxW      = $clog2(MaxPoints);
   localparam int CurW      = $clog2(MaxCurves);
   localparam int CntW      = IdxW + 1;
   localparam int NcW       = $clog2(MaxCurves + 1);

   localparam logic [1:0] FUNC_WRX   = 2'd0;
   localparam logic [1:0] FUNC_WRY   = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   localparam logic CSR_POINTS = 1'b0;
   localparam logic CSR_CURVES = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_HRD, ST_HWAIT, ST_HDEC, ST_ADJ, ST_DRD, ST_DWAIT, ST_DDEC,
      ST_XRD, ST_XWAIT, ST_DIVGO, ST_DIVWAIT, ST_YRD0, ST_YRD1, ST_YWAIT,
      ST_MUL, ST_SUM, ST_OUT
   } state_type;
endpackage

/* hdl/htli_div.sv */
// serial restoring divider, one quotient bit per cycle
// depends on htli_pkg
module htli_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [32:0]   num,
   input  logic signed [32:0]   den,
   output logic                 done,
   output logic signed [31:0]   quot
);
   import htli_pkg::*;
   localparam int NW = 33 + FracBits;
   logic [NW-1:0] q_ff, q_in;
   logic [33:0]   r_ff, r_in, dv_ff, dv_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          neg_ff, neg_in, run_ff, run_in, done_ff, done_in;
   logic [34:0]   trial;
   logic [NW:0]   sq;
   logic [NW-1:0] an;
   logic [32:0]   ad;

   always_comb begin
      an = num[32] ? NW'(-{{FracBits{num[32]}}, num}) : NW'({num, {FracBits{1'b0}}});
      if (num[32]) an = -NW'({num, {FracBits{1'b0}}});
      ad = den[32] ? 33'(-den) : 33'(den);
      q_in = q_ff; r_in = r_ff; dv_in = dv_ff; cnt_in = cnt_ff; neg_in = neg_ff;
      run_in = run_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[NW-1]} - {1'b0, dv_ff};
      if (start) begin
         q_in = an; r_in = '0; dv_in = {1'b0, ad}; cnt_in = 6'(NW);
         neg_in = num[32] ^ den[32]; run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[34]) begin
            r_in = trial[33:0]; q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[32:0], q_ff[NW-1]}; q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
      sq = neg_ff ? -{1'b0, q_ff} : {1'b0, q_ff};
      if (!neg_ff && q_ff > NW'(32'h7fffffff)) quot = 32'sh7fffffff;
      else if (neg_ff && q_ff > NW'(33'h80000000)) quot = 32'sh80000000;
      else quot = sq[31:0];
   end
   assign done = done_ff;

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; dv_ff <= dv_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end
endmodule

/* hdl/hunting_table_linear_interp.sv */
// top level of the table interpolator: tables, hunt sequencer, curve multiply
// depends on htli_pkg and htli_div
//
// usage
// req_ channel carries write items (x or y entry) and query items; csr_ writes
// points_in_use (index 0) and curves_in_use (index 1), to be written only while
// the block is idle; the block itself does not enforce this. a write item gives
// no result. a query item hunts from the stored interval one breakpoint per step
// (read, wait, compare, with a second round when the lower neighbour is compared
// too: single x memory read port), then settles the interval, then the serial
// divider forms the fraction (skipped for one point or equal neighbours), then
// each curve passes through the shared multiplier and y memory port (a single
// result when no curves). req_ready is low while a query runs.
// results leave on rsp_ one per curve (one when no curves), last_of_run on
// the final one. a stall on rsp_ holds the block at that result.
// reset clears the search hint and sets points to 1 and curves to 1; table
// contents are undefined until written.
module hunting_table_linear_interp (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [7:0]         req_entry_index,
   input  logic [1:0]         req_curve_select,
   input  logic signed [31:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_curve_index,
   output logic signed [31:0] rsp_interp_value,
   output logic [8:0]         rsp_interval_number,
   output logic signed [31:0] rsp_fraction,
   output logic               rsp_last_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [8:0]         csr_data
);
   import htli_pkg::*;

   logic signed [31:0] xmem [MaxPoints];
   logic signed [31:0] ymem [MaxPoints*MaxCurves];
   logic [IdxW-1:0] xa;
   logic [IdxW+CurW-1:0] ya;
   logic xrd, yrd;
   logic signed [31:0] xq_ff, yq_ff;

   state_type st_ff, st_in;
   logic [8:0] pts_ff, pts_in;
   logic [2:0] ncr_ff, ncr_in;
   logic [IdxW-1:0] hint_ff, hint_in, i_ff, i_in;
   logic [9:0] n_ff, n_in;
   logic signed [31:0] v_ff, v_in, t0_ff, t0_in, t1_ff, t1_in, s_ff, s_in, y0_ff, y0_in;
   logic [1:0] ph_ff, ph_in;
   logic [CurW-1:0] j_ff, j_in;
   logic [8:0] fn_ff, fn_in;
   logic signed [63:0] p_ff, p_in;
   logic signed [31:0] res_ff, res_in;
   logic [CntW-1:0] m;
   logic [IdxW-1:0] top;
   logic [NcW-1:0] nc;
   logic dstart, ddone;
   logic signed [31:0] dq;
   logic signed [32:0] dnum, dden;
   logic signed [48:0] sum;

   always_comb begin
      m = (pts_ff == 9'd0) ? CntW'(1) : (pts_ff > 9'(MaxPoints)) ? CntW'(MaxPoints)
                                                                 : CntW'(pts_ff);
      top = IdxW'(m - CntW'(1));
      nc = (ncr_ff > 3'(MaxCurves)) ? NcW'(MaxCurves) : NcW'(ncr_ff);
   end

   htli_div u_div (.clock, .reset, .start(dstart), .num(dnum), .den(dden),
                   .done(ddone), .quot(dq));
   assign dnum = 33'(v_ff) - 33'(t0_ff);
   assign dden = 33'(t1_ff) - 33'(t0_ff);

   always_comb begin
      st_in = st_ff; pts_in = pts_ff; ncr_in = ncr_ff; hint_in = hint_ff; i_in = i_ff;
      n_in = n_ff; v_in = v_ff; t0_in = t0_ff; t1_in = t1_ff; s_in = s_ff; y0_in = y0_ff;
      ph_in = ph_ff; j_in = j_ff; fn_in = fn_ff; p_in = p_ff; res_in = res_ff;
      xa = i_ff; ya = {j_ff, i_ff}; dstart = 1'b0; xrd = 1'b0; yrd = 1'b0;
      req_ready = (st_ff == ST_IDLE);
      csr_ready = 1'b1;
      rsp_valid = (st_ff == ST_OUT);
      sum = 49'(y0_ff) + 49'(p_ff >>> FracBits);
      if (csr_valid) begin
         if (csr_index == CSR_POINTS) pts_in = csr_data;
         else ncr_in = csr_data[2:0];
      end
      unique case (st_ff)
         ST_IDLE: if (req_valid && req_func == FUNC_QUERY) begin
            v_in = req_sample; i_in = hint_ff; n_in = '0; st_in = ST_HRD;
         end
         ST_HRD: begin
            // phase 0 reads x[i-1] at top, x[i+1] otherwise; phase 1 reads x[i]
            if (n_ff >= 10'(2*MaxPoints+2)) begin
               st_in = ST_ADJ;
            end else begin
               if (i_ff >= top) i_in = top;
               xa = (i_ff >= top) ? top - IdxW'(1) : i_ff + IdxW'(1);
               if (ph_ff == 2'd1) xa = i_ff;
               xrd = 1'b1;
               st_in = ST_HWAIT;
            end
         end
         ST_HWAIT: st_in = ST_HDEC;
         ST_HDEC: begin
            st_in = ST_HRD; ph_in = 2'd0;
            if (ph_ff == 2'd1) begin
               n_in = n_ff + 10'd1;
               if (v_ff < xq_ff) i_in = i_ff - IdxW'(1);
               else st_in = ST_ADJ;
            end else if (i_ff >= top) begin
               n_in = n_ff + 10'd1;
               if (i_ff != '0 && v_ff < xq_ff) i_in = i_ff - IdxW'(1);
               else st_in = ST_ADJ;
            end else if (v_ff > xq_ff) begin
               n_in = n_ff + 10'd1; i_in = i_ff + IdxW'(1);
            end else if (i_ff == '0) begin
               n_in = n_ff + 10'd1; st_in = ST_ADJ;
            end else begin
               ph_in = 2'd1;
            end
         end
         ST_ADJ: begin
            hint_in = (i_ff > top) ? top : i_ff;
            i_in = (i_ff >= top && i_ff != '0) ? top - IdxW'(1) : ((i_ff > top) ? top : i_ff);
            ph_in = 2'd0; st_in = ST_DRD;
         end
         ST_DRD: begin
            fn_in = 9'(i_ff) + 9'd1;
            // read x[i], x[i+1], x[i+2], x[i-1] in turn
            unique case (ph_ff)
               2'd0: xa = i_ff;
               2'd1: xa = i_ff + IdxW'(1);
               2'd2: xa = i_ff + IdxW'(2);
               default: xa = i_ff - IdxW'(1);
            endcase
            xrd = 1'b1;
            st_in = ST_DWAIT;
         end
         ST_DWAIT: st_in = ST_DDEC;
         ST_DDEC: begin
            st_in = ST_DRD; ph_in = ph_ff + 2'd1;
            unique case (ph_ff)
               2'd0: t0_in = xq_ff;
               2'd1: t1_in = xq_ff;
               2'd2: begin
                  if (CntW'(i_ff) + CntW'(2) < m && v_ff == t1_ff && xq_ff == t1_ff) begin
                     i_in = i_ff + IdxW'(1); ph_in = 2'd0; st_in = ST_XRD;
                  end else if (i_ff == '0) begin
                     ph_in = 2'd0; st_in = ST_XRD;
                  end
               end
               default: begin
                  if (v_ff == t0_ff && xq_ff == t0_ff) i_in = i_ff - IdxW'(1);
                  ph_in = 2'd0; st_in = ST_XRD;
               end
            endcase
         end
         ST_XRD: begin
            xa = (ph_ff == 2'd0) ? i_ff : i_ff + IdxW'(1);
            xrd = 1'b1;
            st_in = ST_XWAIT;
         end
         ST_XWAIT: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd0) begin
               t0_in = xq_ff; xa = i_ff + IdxW'(1); xrd = 1'b1;
            end else begin
               t1_in = xq_ff; st_in = ST_DIVGO;
            end
         end
         ST_DIVGO: begin
            ph_in = 2'd0; j_in = '0;
            if (m == CntW'(1)) begin
               s_in = '0; st_in = (nc == '0) ? ST_OUT : ST_YRD0;
            end else if (t1_ff == t0_ff) begin
               s_in = 32'sd1 <<< (FracBits-1); st_in = (nc == '0) ? ST_OUT : ST_YRD0;
            end else begin
               dstart = 1'b1; st_in = ST_DIVWAIT;
            end
         end
         ST_DIVWAIT: if (ddone) begin
            s_in = dq; st_in = (nc == '0) ? ST_OUT : ST_YRD0;
         end
         ST_YRD0: begin
            ya = {j_ff, i_ff}; yrd = 1'b1; st_in = ST_YRD1;
         end
         ST_YRD1: begin
            y0_in = yq_ff;
            ya = {j_ff, i_ff + IdxW'(1)}; yrd = 1'b1; st_in = ST_YWAIT;
         end
         ST_YWAIT: begin
            st_in = ST_MUL;
         end
         ST_MUL: begin
            p_in = (m == CntW'(1)) ? 64'sd0 : s_ff * (64'(yq_ff) - 64'(y0_ff));
            st_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum > 49'sh7fffffff) res_in = 32'sh7fffffff;
            else if (sum < -49'sh80000000) res_in = 32'sh80000000;
            else res_in = sum[31:0];
            st_in = ST_OUT;
         end
         ST_OUT: if (rsp_ready) begin
            if (nc == '0 || NcW'(j_ff) + NcW'(1) >= nc) st_in = ST_IDLE;
            else begin
               j_in = j_ff + CurW'(1); st_in = ST_YRD0;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp_curve_index = (nc == '0) ? 2'd0 : 2'(j_ff);
   assign rsp_interp_value = (nc == '0) ? 32'sd0 : res_ff;
   assign rsp_interval_number = (nc == '0) ? fn_ff : 9'(i_ff) + 9'd1;
   assign rsp_fraction = s_ff;
   assign rsp_last_of_run = (nc == '0) || (NcW'(j_ff) + NcW'(1) >= nc);

   always_ff @(posedge clock) begin
      if (xrd) xq_ff <= xmem[xa];
      if (yrd) yq_ff <= ymem[ya];
      if (st_ff == ST_IDLE && req_valid && req_func == FUNC_WRX)
         xmem[req_entry_index] <= req_sample;
      if (st_ff == ST_IDLE && req_valid && req_func == FUNC_WRY)
         ymem[{req_curve_select, req_entry_index}] <= req_sample;
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; n_ff <= n_in; v_ff <= v_in; t0_ff <= t0_in; t1_ff <= t1_in;
      s_ff <= s_in; y0_ff <= y0_in; j_ff <= j_in; fn_ff <= fn_in; p_ff <= p_in;
      res_ff <= res_in;
      if (reset) begin
         st_ff <= ST_IDLE; pts_ff <= 9'd1; ncr_ff <= 3'd1; hint_ff <= '0; ph_ff <= '0;
      end else begin
         st_ff <= st_in; pts_ff <= pts_in; ncr_ff <= ncr_in; hint_ff <= hint_in;
         ph_ff <= ph_in;
      end
   end
endmodule

/* hdl/htli_checker.sv */
// port-level checks for the table interpolator
// depends on hunting_table_linear_interp_assert.svh
`include "hunting_table_linear_interp_assert.svh"
module htli_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last_of_run
);
   `HTLI_ASSERT_IMP(a_excl, rsp_valid, !req_ready)
   `HTLI_ASSERT_NXT(a_busy, rsp_valid && rsp_ready && !rsp_last_of_run, !req_ready)
   `HTLI_ASSERT_NXT(a_hold, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind hunting_table_linear_interp htli_checker u_chk (.*);
